// ===== src/pse_pkg.sv =====
package pse_pkg;

  localparam int NUM_W = 20;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [1:0]       func_t;
  typedef logic [1:0]       status_t;

  localparam func_t FUNC_BUILD = 2'd0;
  localparam func_t FUNC_TEST  = 2'd1;
  localparam func_t FUNC_NEXT  = 2'd2;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_NOT_BUILT = 2'd1;
  localparam status_t STATUS_RANGE     = 2'd2;
  localparam status_t STATUS_NONE      = 2'd3;

  localparam num_t LIMIT_FLOOR = 20'd25;
  localparam num_t LIMIT_RESET = 20'd10000;

endpackage

// ===== src/prime_sieve_engine.sv =====
// Prime sieve engine: a one-bit-per-number primality map over 0..limit.
// Input channel (in_valid/in_ready) carries func and number; func 0 builds
// the map, func 1 tests number, func 2 returns the first prime above number.
// Output channel (out_valid/out_ready) carries status, is_prime, higher_prime;
// every accepted item gives exactly one result transfer.
// cfg_we/cfg_data write the limit register; a write clears the built mark.
// The block takes one item at a time: in_ready is high only while idle, so
// the next transfer comes at the earliest in the cycle after a result loads.
// A result waits in the output register, so the next item is accepted while
// the receiver stalls; a new result waits internally until that register
// frees up, and the input stalls meanwhile.
// From the accepting edge to the result in the output register: a test
// reads the map in S_T_RD and S_T_CHK, then loads the result in S_FIN;
// func 3 and the not-built and above-limit answers go straight to S_FIN.
// A next search scans upward one number at a time, stopping past the limit;
// the single read port of the map sets the pace. A build clears the map up
// to the limit, then copies, strikes and scans entries, running the divider
// once per prime of the plain stage.
// Reset: built mark cleared, limit back to 10000; the map is not cleared,
// a build clears it before sieving.
module prime_sieve_engine #(
  parameter int MAX_LIMIT = 1048575
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  input  logic [19:0]           number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic                  is_prime,
  output logic [19:0]           higher_prime,
  input  logic                  cfg_we,
  input  logic [19:0]           cfg_data
);

  localparam int NW = pse_pkg::NUM_W;
  localparam int VW = NW + 2;          // wheel span ends run up to twice the limit
  localparam int PW = VW + NW;         // product width
  localparam int AW = $clog2(MAX_LIMIT + 1);
  localparam int CW = $clog2(NW);

  // sequencer codes
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CLR     = 5'd1;
  localparam logic [4:0] S_SC_RD   = 5'd2;
  localparam logic [4:0] S_SC_CHK  = 5'd3;
  localparam logic [4:0] S_T_RD    = 5'd4;
  localparam logic [4:0] S_T_CHK   = 5'd5;
  localparam logic [4:0] S_Q_NEXT  = 5'd6;
  localparam logic [4:0] S_W_TOP   = 5'd7;
  localparam logic [4:0] S_W_CUT   = 5'd8;
  localparam logic [4:0] S_W_CUT2  = 5'd9;
  localparam logic [4:0] S_CP_RD   = 5'd10;
  localparam logic [4:0] S_CP_WR   = 5'd11;
  localparam logic [4:0] S_ST_RD   = 5'd12;
  localparam logic [4:0] S_ST_WR   = 5'd13;
  localparam logic [4:0] S_W_NEXT  = 5'd14;
  localparam logic [4:0] S_W_NEXT2 = 5'd15;
  localparam logic [4:0] S_W_TEST  = 5'd16;
  localparam logic [4:0] S_W_TEST2 = 5'd17;
  localparam logic [4:0] S_F_SET   = 5'd18;
  localparam logic [4:0] S_P_TOP   = 5'd19;
  localparam logic [4:0] S_DIV     = 5'd20;
  localparam logic [4:0] S_P_NEXT  = 5'd21;
  localparam logic [4:0] S_P_SQ    = 5'd22;
  localparam logic [4:0] S_P_SQ2   = 5'd23;
  localparam logic [4:0] S_END     = 5'd24;
  localparam logic [4:0] S_FIN     = 5'd25;

  logic [4:0]            state;
  logic [4:0]            sc_ret;       // where a scan returns to
  logic                  built;
  logic                  plain;        // past the wheel: plain sieving stage
  pse_pkg::num_t         limit;
  pse_pkg::num_t         lim;
  pse_pkg::num_t         cur_num;
  pse_pkg::num_t         current_prime;
  logic [VW-1:0]         cycle_end;
  logic [VW-1:0]         span;
  logic [VW-1:0]         stop;
  logic [VW-1:0]         i;
  pse_pkg::num_t         np;
  pse_pkg::num_t         found;
  pse_pkg::num_t         quot;
  pse_pkg::num_t         rem;
  logic [CW-1:0]         cnt;
  pse_pkg::status_t      r_status;
  logic                  r_prime;
  pse_pkg::num_t         r_next;

  // shared multiplier, one operand is always the current prime
  logic [VW-1:0]         mul_a;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         cand;

  // divider step
  logic [NW:0]           rem_sh;
  logic [NW:0]           rem_diff;
  logic                  div_ge;
  pse_pkg::num_t         quot_next;

  // map memory
  logic                  mem [0:MAX_LIMIT];
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic                  mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic                  mem_rdata;

  logic [VW-1:0]         lim_v;
  logic [PW-1:0]         lim_p;
  logic [VW-1:0]         p_v;
  logic [VW-1:0]         rd_idx;

  assign lim = (limit < pse_pkg::LIMIT_FLOOR || limit > NW'(MAX_LIMIT)) ?
               pse_pkg::LIMIT_FLOOR : limit;
  assign lim_v = VW'(lim);
  assign lim_p = PW'(lim);
  assign p_v   = VW'(current_prime);
  assign cand  = prod + PW'(np) - PW'(1);

  assign rem_sh    = {rem, quot[NW-1]};
  assign rem_diff  = rem_sh - {1'b0, current_prime};
  assign div_ge    = ~rem_diff[NW];
  assign quot_next = {quot[NW-2:0], div_ge};

  assign in_ready = (state == S_IDLE);

  // operand select for the multiplier
  always_comb begin
    case (state)
      S_W_CUT, S_W_NEXT: mul_a = span;
      S_ST_RD:           mul_a = i;
      S_W_TEST:          mul_a = cycle_end;
      S_P_SQ:            mul_a = p_v;
      default:           mul_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * PW'(current_prime);
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i[AW-1:0];
    mem_wdata = 1'b0;
    rd_idx    = i;
    case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = (i == VW'(2)) || (i == VW'(3)) || (i == VW'(5));
      end
      S_CP_RD: rd_idx = i - span;
      S_CP_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      S_ST_WR: begin
        mem_we    = mem_rdata && (prod <= lim_p);
        mem_waddr = prod[AW-1:0];
      end
      S_T_RD: rd_idx = VW'(cur_num);
      default: ;
    endcase
    mem_raddr = rd_idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      built         <= 1'b0;
      limit         <= pse_pkg::LIMIT_RESET;
      current_prime <= NW'(2);
      cycle_end     <= VW'(2);
      out_valid     <= 1'b0;
      plain         <= 1'b0;
    end else begin
      // drop the result after its transfer unless a new one loads now
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        limit <= cfg_data;
        built <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_num  <= number;
            r_prime  <= 1'b0;
            r_next   <= '0;
            case (func)
              pse_pkg::FUNC_BUILD: begin
                r_status <= pse_pkg::STATUS_OK;
                i        <= '0;
                plain    <= 1'b0;
                state    <= S_CLR;
              end
              pse_pkg::FUNC_TEST, pse_pkg::FUNC_NEXT: begin
                if (!built) begin
                  r_status <= pse_pkg::STATUS_NOT_BUILT;
                  state    <= S_FIN;
                end else if (number > lim) begin
                  r_status <= pse_pkg::STATUS_RANGE;
                  state    <= S_FIN;
                end else if (func == pse_pkg::FUNC_TEST) begin
                  r_status <= pse_pkg::STATUS_OK;
                  state    <= S_T_RD;
                end else begin
                  r_status <= pse_pkg::STATUS_OK;
                  i        <= VW'(number) + VW'(1);
                  sc_ret   <= S_Q_NEXT;
                  state    <= S_SC_RD;
                end
              end
              default: begin
                r_status <= pse_pkg::STATUS_OK;
                state    <= S_FIN;
              end
            endcase
          end
        end
        S_T_RD: state <= S_T_CHK;
        S_T_CHK: begin
          r_prime <= mem_rdata;
          state   <= S_FIN;
        end
        S_Q_NEXT: begin
          r_next <= found;
          if (found == '0) begin
            r_status <= pse_pkg::STATUS_NONE;
          end
          state <= S_FIN;
        end
        // scan up for the next set bit, stop past the limit
        S_SC_RD: begin
          if (i > lim_v) begin
            found <= '0;
            state <= sc_ret;
          end else begin
            state <= S_SC_CHK;
          end
        end
        S_SC_CHK: begin
          if (mem_rdata) begin
            found <= i[NW-1:0];
            state <= sc_ret;
          end else begin
            i     <= i + VW'(1);
            state <= S_SC_RD;
          end
        end
        // clear the map and seed 2, 3 and 5
        S_CLR: begin
          if (i == lim_v) begin
            current_prime <= NW'(2);
            cycle_end     <= VW'(2);
            state         <= S_W_TOP;
          end
          i <= i + VW'(1);
        end
        S_W_TOP: begin
          span   <= cycle_end - p_v + VW'(1);
          i      <= p_v + VW'(1);
          sc_ret <= S_W_CUT;
          state  <= S_SC_RD;
        end
        S_W_CUT: begin
          np    <= found;
          state <= S_W_CUT2;
        end
        S_W_CUT2: begin
          if (np != '0 && cand < lim_p) begin
            stop <= cand[VW-1:0];
          end else begin
            stop <= lim_v;
          end
          i     <= cycle_end + VW'(1);
          state <= S_CP_RD;
        end
        // copy the pattern forward by the wheel distance
        S_CP_RD: begin
          if (i > stop) begin
            if (plain) begin
              state <= S_P_TOP;
            end else begin
              i     <= cycle_end;
              state <= S_ST_RD;
            end
          end else begin
            state <= S_CP_WR;
          end
        end
        S_CP_WR: begin
          i     <= i + VW'(1);
          state <= S_CP_RD;
        end
        // strike p * i for every marked i, top down
        S_ST_RD: begin
          if (i < p_v) begin
            i      <= p_v + VW'(1);
            sc_ret <= plain ? S_P_NEXT : S_W_NEXT;
            state  <= S_SC_RD;
          end else begin
            state <= S_ST_WR;
          end
        end
        S_ST_WR: begin
          i     <= i - VW'(1);
          state <= S_ST_RD;
        end
        S_W_NEXT: begin
          if (found == '0) begin
            state <= S_F_SET;
          end else begin
            np    <= found;
            state <= S_W_NEXT2;
          end
        end
        S_W_NEXT2: begin
          cycle_end     <= cand[VW-1:0];
          current_prime <= np;
          state         <= S_W_TEST;
        end
        S_W_TEST: state <= S_W_TEST2;
        S_W_TEST2: begin
          state <= (prod <= lim_p) ? S_W_TOP : S_F_SET;
        end
        // last wheel copy runs to the limit, then plain sieving
        S_F_SET: begin
          span  <= cycle_end - p_v + VW'(1);
          i     <= cycle_end + VW'(1);
          stop  <= lim_v;
          plain <= 1'b1;
          state <= S_CP_RD;
        end
        S_P_TOP: begin
          quot  <= lim;
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        // restoring divide: limit / p, one quotient bit a cycle
        S_DIV: begin
          if (div_ge) begin
            rem <= rem_diff[NW-1:0];
          end else begin
            rem <= rem_sh[NW-1:0];
          end
          quot <= quot_next;
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(NW - 1)) begin
            i     <= VW'(quot_next);
            state <= S_ST_RD;
          end
        end
        S_P_NEXT: begin
          if (found == '0) begin
            state <= S_END;
          end else begin
            current_prime <= found;
            state         <= S_P_SQ;
          end
        end
        S_P_SQ: state <= S_P_SQ2;
        S_P_SQ2: begin
          state <= (prod <= lim_p) ? S_P_TOP : S_END;
        end
        S_END: begin
          built <= 1'b1;
          state <= S_FIN;
        end
        // hold the result until the output register frees up
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= r_status;
            is_prime     <= r_prime;
            higher_prime <= r_next;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/prime_sieve_engine_test.sv =====
`timescale 1ns / 100ps

module prime_sieve_engine_test;

  // Selector value with no operation behind it; the block must answer it with
  // a plain ok result and change nothing.
  localparam pse_pkg::func_t FUNC_SPARE = 2'd3;

  localparam longint MAP_TOP        = 1048575;
  localparam int     HOLDOFF_CYCLES = 300;
  localparam int     REPORT_LIMIT   = 10;

  typedef struct packed {
    pse_pkg::status_t status;
    logic             is_prime;
    pse_pkg::num_t    higher_prime;
  } answer_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  pse_pkg::func_t   func;
  pse_pkg::num_t    number;
  logic             out_valid;
  logic             out_ready;
  pse_pkg::status_t status;
  logic             is_prime;
  pse_pkg::num_t    higher_prime;
  logic             cfg_we;
  pse_pkg::num_t    cfg_data;

  prime_sieve_engine dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .number       (number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .is_prime     (is_prime),
    .higher_prime (higher_prime),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  // Local copy of the block's state: the primality map, the built mark and
  // the limit register.
  bit            prime_map [0:MAP_TOP];
  bit            sieve_built;
  pse_pkg::num_t limit_reg;

  // Answers owed by the block, oldest first.
  answer_t pending_answers[$];

  // Sender burst state and the request that starts the long receiver hold-off.
  int      burst_left;
  bit      holdoff_req;

  int      error_count;
  int      results_checked;
  int      builds_sent;
  int      tests_sent;
  int      nexts_sent;
  int      spares_sent;
  int      limit_writes;

  // ---------------------------------------------------------------------------
  // Sieve prediction
  // ---------------------------------------------------------------------------

  function automatic longint active_limit();
    // Limits below the floor behave as the floor.
    return (limit_reg < pse_pkg::LIMIT_FLOOR) ? longint'(pse_pkg::LIMIT_FLOOR)
                                              : longint'(limit_reg);
  endfunction

  function automatic bit map_bit(longint i);
    return (i > MAP_TOP) ? 1'b0 : prime_map[i];
  endfunction

  // First marked entry above from, up to top; 0 when there is none.
  function automatic longint first_marked_above(longint from, longint top);
    for (longint i = from + 1; i <= top; i++) begin
      if (map_bit(i)) return i;
    end
    return 0;
  endfunction

  // Copy the pattern forward by the wheel distance, starting right after span
  // end e. Unless told to run to the top, stop where the next span will end.
  function automatic void spread_wheel(longint p, longint e, longint lim, bit to_top);
    longint span;
    longint stop;
    longint np;
    longint cand;
    span = e - p + 1;
    stop = lim;
    if (!to_top) begin
      np   = first_marked_above(p, lim);
      cand = p * span + np - 1;
      if (np != 0 && cand < lim) stop = cand;
    end
    for (longint i = e + 1; i <= stop; i++) begin
      prime_map[i] = map_bit(i - span);
    end
  endfunction

  // Clear p * i for every marked i, walking from top down to p.
  function automatic void strike_multiples(longint p, longint top, longint lim);
    for (longint i = top; i >= p; i--) begin
      if (map_bit(i) && i * p <= lim) prime_map[i * p] = 1'b0;
    end
  endfunction

  function automatic void sieve_rebuild();
    longint lim;
    longint p;
    longint e;
    longint np;
    lim = active_limit();
    p   = 2;
    e   = 2;
    // Entries above the limit are never touched, so clear only up to it.
    for (longint i = 0; i <= lim; i++) prime_map[i] = 1'b0;
    prime_map[2] = 1'b1;
    prime_map[3] = 1'b1;
    prime_map[5] = 1'b1;

    // Wheel stage: grow the span by each new prime while it fits.
    forever begin
      spread_wheel(p, e, lim, 1'b0);
      strike_multiples(p, e, lim);
      np = first_marked_above(p, lim);
      if (np == 0) break;
      e = p * (e - p + 1) + np - 1;
      p = np;
      if (p * e > lim) break;
    end
    spread_wheel(p, e, lim, 1'b1);

    // Plain stage: strike the remaining primes up to the square root.
    forever begin
      strike_multiples(p, lim / p, lim);
      np = first_marked_above(p, lim);
      if (np == 0) break;
      p = np;
      if (p * p > lim) break;
    end

    prime_map[0] = 1'b0;
    prime_map[1] = 1'b0;
    sieve_built  = 1'b1;
  endfunction

  function automatic answer_t predict_answer(pse_pkg::func_t f, pse_pkg::num_t n);
    answer_t a;
    longint  lim;
    longint  found;
    a.status       = pse_pkg::STATUS_OK;
    a.is_prime     = 1'b0;
    a.higher_prime = '0;
    lim = active_limit();
    if (f == pse_pkg::FUNC_BUILD) begin
      sieve_rebuild();
    end else if (f == pse_pkg::FUNC_TEST || f == pse_pkg::FUNC_NEXT) begin
      if (!sieve_built) begin
        a.status = pse_pkg::STATUS_NOT_BUILT;
      end else if (longint'(n) > lim) begin
        a.status = pse_pkg::STATUS_RANGE;
      end else if (f == pse_pkg::FUNC_TEST) begin
        a.is_prime = prime_map[n];
      end else begin
        found = first_marked_above(longint'(n), lim);
        if (found == 0) a.status = pse_pkg::STATUS_NONE;
        else a.higher_prime = pse_pkg::num_t'(found);
      end
    end
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog, receiver and result checker
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run well above the slowest legal schedule, builds included.
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: pick a stall mode for a random stretch (always ready, half
  // ready, mostly stalled), and on request hold off entirely for a long,
  // counted stretch so the block backs up into its input.
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_left   = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // Compare every result transfer with the oldest owed answer.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected result: status %0d is_prime %0d higher_prime %0d",
                   status, is_prime, higher_prime);
      end else begin
        want = pending_answers.pop_front();
        results_checked++;
        if (status !== want.status || is_prime !== want.is_prime ||
            higher_prime !== want.higher_prime) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display({"mismatch at %0t: status %0d/%0d is_prime %0d/%0d",
                      " higher_prime %0d/%0d (exp/act)"},
                     $realtime, want.status, status, want.is_prime, is_prime,
                     want.higher_prime, higher_prime);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration
  // ---------------------------------------------------------------------------

  // Offer one command and hold it until the transfer; predict on acceptance.
  // Between bursts drop valid for a random gap, sometimes none at all.
  task automatic send_command(input pse_pkg::func_t f, input pse_pkg::num_t n);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    func     <= f;
    number   <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_answers.insert(pending_answers.size(), predict_answer(f, n));
    case (f)
      pse_pkg::FUNC_BUILD: builds_sent++;
      pse_pkg::FUNC_TEST:  tests_sent++;
      pse_pkg::FUNC_NEXT:  nexts_sent++;
      default:             spares_sent++;
    endcase
  endtask

  // Drop valid and wait until every owed answer has arrived.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the limit while the block is idle; any write clears the built mark.
  task automatic write_limit(input pse_pkg::num_t value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    limit_reg   = value;
    sieve_built = 1'b0;
    limit_writes++;
  endtask

  // Random command: mostly tests and next searches, numbers spread over the
  // covered range, near its top and above it; rare rebuilds on small maps.
  task automatic send_random_query(input longint lim, input bit may_build);
    pse_pkg::func_t f;
    pse_pkg::num_t  n;
    int             pick;
    pick = $urandom_range(0, 99);
    if (pick < 46) f = pse_pkg::FUNC_TEST;
    else if (pick < 92) f = pse_pkg::FUNC_NEXT;
    else if (pick < 99 || !may_build) f = FUNC_SPARE;
    else f = pse_pkg::FUNC_BUILD;

    pick = $urandom_range(0, 99);
    if (pick < 60) n = pse_pkg::num_t'($urandom_range(0, 32'(lim)));
    else if (pick < 72) n = pse_pkg::num_t'($urandom_range(0, 40));
    else if (pick < 84) n = pse_pkg::num_t'(lim - $urandom_range(0, 12));
    else if (pick < 92 && lim < MAP_TOP)
      n = pse_pkg::num_t'($urandom_range(32'(lim + 1), 32'(MAP_TOP)));
    else n = pse_pkg::num_t'($urandom);
    send_command(f, n);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Queries before any build answer not built; the spare selector is a no-op.
  task automatic check_unbuilt_queries();
    send_command(pse_pkg::FUNC_TEST, 20'd0);
    send_command(pse_pkg::FUNC_NEXT, 20'hFFFFF);
    send_command(FUNC_SPARE, 20'h5A5A5);
  endtask

  // Build at the reset limit, then probe the edges of the covered range.
  task automatic check_default_build();
    write_limit(pse_pkg::LIMIT_RESET);
    send_command(pse_pkg::FUNC_BUILD, 20'hFFFFF);
    send_command(pse_pkg::FUNC_TEST, 20'd0);
    send_command(pse_pkg::FUNC_TEST, 20'd1);
    send_command(pse_pkg::FUNC_TEST, 20'd2);
    send_command(pse_pkg::FUNC_TEST, 20'd9973);
    send_command(pse_pkg::FUNC_TEST, 20'd9999);
    send_command(pse_pkg::FUNC_TEST, 20'd10000);
    send_command(pse_pkg::FUNC_TEST, 20'd10001);
    send_command(pse_pkg::FUNC_TEST, 20'hFFFFF);
    send_command(pse_pkg::FUNC_NEXT, 20'd0);
    send_command(pse_pkg::FUNC_NEXT, 20'd9973);
    send_command(pse_pkg::FUNC_NEXT, 20'd10000);
    send_command(pse_pkg::FUNC_NEXT, 20'hFFFFF);
    send_command(FUNC_SPARE, 20'hFFFFF);
  endtask

  // A zero limit acts as the floor; rewriting the same value clears built.
  task automatic check_limit_floor();
    write_limit(20'd0);
    send_command(pse_pkg::FUNC_BUILD, 20'd0);
    send_command(pse_pkg::FUNC_TEST, 20'd25);
    send_command(pse_pkg::FUNC_TEST, 20'd26);
    send_command(pse_pkg::FUNC_NEXT, 20'd22);
    send_command(pse_pkg::FUNC_NEXT, 20'd23);
    write_limit(20'd0);
    send_command(pse_pkg::FUNC_TEST, 20'd23);
  endtask

  // Phases over a spread of limits: a few unbuilt queries, a build, then a
  // long random stream against the fresh map.
  task automatic check_random_limits();
    pse_pkg::num_t lim_w;
    longint        lim;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       lim_w = 20'd24;
        1:       lim_w = 20'd26;
        2:       lim_w = 20'd100;
        7:       lim_w = pse_pkg::num_t'($urandom_range(0, 24));
        8:       lim_w = 20'd30031;
        9:       lim_w = pse_pkg::num_t'($urandom_range(20000, 30000));
        default: lim_w = pse_pkg::num_t'($urandom_range(27, 3000));
      endcase
      write_limit(lim_w);
      lim = active_limit();
      repeat (3) send_random_query(lim, 1'b0);
      send_command(pse_pkg::FUNC_BUILD, pse_pkg::num_t'($urandom));
      repeat (110) send_random_query(lim, lim <= 1000);
    end
  endtask

  // Largest limit, never built: every test and next search answers not built.
  task automatic check_unbuilt_full_range();
    write_limit(20'hFFFFF);
    send_command(pse_pkg::FUNC_TEST, 20'hFFFFF);
    send_command(pse_pkg::FUNC_NEXT, 20'd0);
    repeat (10) send_random_query(MAP_TOP, 1'b0);
  endtask

  // Hold the receiver off for a long stretch while commands keep coming, so
  // the block fills and stalls its input.
  task automatic check_output_stall();
    write_limit(20'd500);
    send_command(pse_pkg::FUNC_BUILD, 20'd0);
    drain();
    holdoff_req = 1'b1;
    repeat (30) send_random_query(500, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    func      = pse_pkg::FUNC_BUILD;
    number    = '0;
    cfg_we    = 1'b0;
    cfg_data  = '0;

    sieve_built     = 1'b0;
    limit_reg       = pse_pkg::LIMIT_RESET;
    burst_left      = 0;
    holdoff_req     = 1'b0;
    error_count     = 0;
    results_checked = 0;
    builds_sent     = 0;
    tests_sent      = 0;
    nexts_sent      = 0;
    spares_sent     = 0;
    limit_writes    = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_unbuilt_queries();
    check_default_build();
    check_limit_floor();
    check_unbuilt_full_range();
    check_output_stall();
    check_random_limits();

    // Let any stray result show up before the verdict.
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d builds, %0d tests, %0d next searches, %0d spare commands",
             builds_sent, tests_sent, nexts_sent, spares_sent);
    $display("over %0d limit writes; checked %0d results, %0d failures",
             limit_writes, results_checked, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pse_pkg.sv
src/prime_sieve_engine.sv
bench/prime_sieve_engine_test.sv
